// ===== design/c2p_pkg.sv =====
// c2p_pkg: shared constants and types for the cartesian to polar unit
// no dependencies; compiled first
`default_nettype none

package c2p_pkg;

  // fixed field widths and fixed-point formats
  localparam int ANGLE_WIDTH  = 16;
  localparam int GUARD_SHIFT  = 30;
  localparam int MAX_ITER     = 32;
  localparam int Z_WIDTH      = 35;
  localparam int ROUND_SHIFT  = 17;
  localparam int Q_WIDTH      = Z_WIDTH - ROUND_SHIFT;

  // angle constants, radians
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int          PI_Q13      = 25736;
  localparam int          TWO_PI_Q13  = 51471;

  // round(atan(2^-i) * 2^30)
  localparam logic [29:0] ATAN_Q30 [MAX_ITER] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,
    30'd64,        30'd32,        30'd16,        30'd8,
    30'd4,         30'd2,         30'd1,         30'd0
  };

  // quadrant information that rides along the pipeline
  typedef struct packed {
    logic y_zero;
    logic y_neg;
    logic x_neg;
  } c2p_flags_t;

endpackage

`default_nettype wire

// ===== design/c2p_if.sv =====
// c2p_if: valid/ready channels for the point input and the polar result
// depends on c2p_pkg
`default_nettype none

interface c2p_point_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_polar_if
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] radius;
  logic [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output radius, output angle, input ready);
  modport sink   (input valid, input radius, input angle, output ready);
endinterface

`default_nettype wire

// ===== design/cartesian_to_polar_unit.sv =====
// cartesian_to_polar_unit: pipelined cordic angle and digit-by-digit square root
// depends on c2p_pkg and the c2p_point_if / c2p_polar_if channels
`default_nettype none

// Converts a signed (x, y) point to a rounded radius and an angle in unsigned
// Q3.13 radians, range [0, 2*pi). One transaction is accepted every clock
// cycle while ready is high. Each point passes the input register, the
// squares and pre-rotation register, the register where the sum of squares
// enters, the unrolled pipeline in which each stage does at most one cordic
// micro-rotation and resolves at most one bit of the square root, and the output
// register. A two-entry output buffer lets the pipeline keep moving while one
// result waits; ready drops only once both entries hold results. The unit keeps no state between points.
module cartesian_to_polar_unit
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  c2p_point_if.sink     pt_i,
  c2p_polar_if.source   pol_o
);

  localparam int IT = (ITERATIONS > MAX_ITER) ? MAX_ITER : ITERATIONS;
  localparam int NS = (IT > COORD_WIDTH) ? IT : COORD_WIDTH;
  localparam int CW = COORD_WIDTH + GUARD_SHIFT + 3;
  localparam int SW = 2 * COORD_WIDTH;

  localparam logic signed [Z_WIDTH-1:0] HALF_PI_Z  = Z_WIDTH'(HALF_PI_Q30);
  localparam logic signed [Z_WIDTH-1:0] ROUND_HALF = Z_WIDTH'(1) <<< (ROUND_SHIFT - 1);
  localparam logic signed [Q_WIDTH:0]   PI_S       = (Q_WIDTH + 1)'(PI_Q13);
  localparam logic signed [Q_WIDTH:0]   TWO_PI_S   = (Q_WIDTH + 1)'(TWO_PI_Q13);
  localparam logic signed [Q_WIDTH:0]   TWO_PI_M1  = (Q_WIDTH + 1)'(TWO_PI_Q13 - 1);

  logic en;

  // input register
  logic                          v0_q;
  logic signed [COORD_WIDTH-1:0] x0_q, y0_q;

  // squares and quadrant pre-rotation
  logic                          v1_q;
  logic [SW-1:0]                 xx_q, yy_q;
  logic signed [CW-1:0]          cx1_q, cy1_q;
  logic signed [Z_WIDTH-1:0]     z1_q;
  c2p_flags_t                    fl1_q;

  logic signed [SW-1:0]          sqx, sqy;
  logic signed [CW-1:0]          xs, ys, cx1_d, cy1_d;
  logic signed [Z_WIDTH-1:0]     z1_d;

  // rotation / root stages
  logic                          sv_q   [NS+1];
  logic signed [CW-1:0]          cx_q   [NS+1];
  logic signed [CW-1:0]          cy_q   [NS+1];
  logic signed [Z_WIDTH-1:0]     z_q    [NS+1];
  logic [SW-1:0]                 rem_q  [NS+1];
  logic [SW-1:0]                 root_q [NS+1];
  c2p_flags_t                    fl_q   [NS+1];

  logic signed [CW-1:0]          cx_d   [NS];
  logic signed [CW-1:0]          cy_d   [NS];
  logic signed [Z_WIDTH-1:0]     z_d    [NS];
  logic [SW-1:0]                 rem_d  [NS];
  logic [SW-1:0]                 root_d [NS];

  // result formatting
  logic signed [Z_WIDTH-1:0]     z_rnd;
  logic signed [Q_WIDTH-1:0]     q_raw;
  logic signed [Q_WIDTH:0]       q_ext, q_low, ang_sel;
  logic [COORD_WIDTH-1:0]        rad_res;
  logic [ANGLE_WIDTH-1:0]        ang_res;

  // output register and skid entry
  logic                          out_v_q, skid_v_q;
  logic [COORD_WIDTH-1:0]        rad_q, skid_rad_q;
  logic [ANGLE_WIDTH-1:0]        ang_q, skid_ang_q;

  // the pipeline moves whenever the skid entry is free
  assign en         = !skid_v_q;
  assign pt_i.ready = en;

  // input capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= pt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= pt_i.x_coord;
      y0_q <= pt_i.y_coord;
    end
  end

  // squares and pre-rotation into the right half plane
  assign sqx = SW'(x0_q) * SW'(x0_q);
  assign sqy = SW'(y0_q) * SW'(y0_q);
  assign xs  = {{(CW - COORD_WIDTH){x0_q[COORD_WIDTH-1]}}, x0_q} <<< GUARD_SHIFT;
  assign ys  = {{(CW - COORD_WIDTH){y0_q[COORD_WIDTH-1]}}, y0_q} <<< GUARD_SHIFT;

  always_comb begin
    cx1_d = xs;
    cy1_d = ys;
    z1_d  = '0;
    if (x0_q[COORD_WIDTH-1]) begin
      if (!y0_q[COORD_WIDTH-1]) begin
        cx1_d = ys;
        cy1_d = -xs;
        z1_d  = HALF_PI_Z;
      end else begin
        cx1_d = -ys;
        cy1_d = xs;
        z1_d  = -HALF_PI_Z;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q         <= sqx;
      yy_q         <= sqy;
      cx1_q        <= cx1_d;
      cy1_q        <= cy1_d;
      z1_q         <= z1_d;
      fl1_q.y_zero <= (y0_q == '0);
      fl1_q.y_neg  <= y0_q[COORD_WIDTH-1];
      fl1_q.x_neg  <= x0_q[COORD_WIDTH-1];
    end
  end

  // sum of squares enters the root pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0]   <= cx1_q;
      cy_q[0]   <= cy1_q;
      z_q[0]    <= z1_q;
      rem_q[0]  <= xx_q + yy_q;
      root_q[0] <= '0;
      fl_q[0]   <= fl1_q;
    end
  end

  // at most one micro-rotation and at most one root bit per stage
  for (genvar j = 0; j < NS; j++) begin : g_stage
    if (j < IT) begin : g_rot
      localparam logic signed [Z_WIDTH-1:0] ATAN_J = Z_WIDTH'(ATAN_Q30[j]);
      logic signed [CW-1:0] dx, dy;
      logic                 up;

      assign dx = cy_q[j] >>> j;
      assign dy = cx_q[j] >>> j;
      assign up = !cy_q[j][CW-1];

      assign cx_d[j] = up ? cx_q[j] + dx : cx_q[j] - dx;
      assign cy_d[j] = up ? cy_q[j] - dy : cy_q[j] + dy;
      assign z_d[j]  = up ? z_q[j] + ATAN_J : z_q[j] - ATAN_J;
    end else begin : g_rot_pass
      assign cx_d[j] = cx_q[j];
      assign cy_d[j] = cy_q[j];
      assign z_d[j]  = z_q[j];
    end

    if (j < COORD_WIDTH) begin : g_root
      localparam logic [SW:0] BIT_J = (SW + 1)'(1) << (2 * (COORD_WIDTH - 1 - j));
      logic [SW:0] trial;
      logic        take;

      assign trial     = {1'b0, root_q[j]} + BIT_J;
      assign take      = ({1'b0, rem_q[j]} >= trial);
      assign rem_d[j]  = take ? rem_q[j] - trial[SW-1:0] : rem_q[j];
      assign root_d[j] = take ? (root_q[j] >> 1) + BIT_J[SW-1:0] : (root_q[j] >> 1);
    end else begin : g_root_pass
      assign rem_d[j]  = rem_q[j];
      assign root_d[j] = root_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (en) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[j+1]   <= cx_d[j];
        cy_q[j+1]   <= cy_d[j];
        z_q[j+1]    <= z_d[j];
        rem_q[j+1]  <= rem_d[j];
        root_q[j+1] <= root_d[j];
        fl_q[j+1]   <= fl_q[j];
      end
    end
  end

  // round the root to nearest
  assign rad_res = root_q[NS][COORD_WIDTH-1:0]
                 + COORD_WIDTH'(rem_q[NS] > root_q[NS]);

  // round the angle to Q3.13 and fold it into its half turn
  assign z_rnd = z_q[NS] + ROUND_HALF;
  assign q_raw = z_rnd[Z_WIDTH-1:ROUND_SHIFT];
  assign q_ext = {q_raw[Q_WIDTH-1], q_raw};
  assign q_low = q_ext + TWO_PI_S;

  always_comb begin
    priority if (fl_q[NS].y_zero) begin
      ang_sel = fl_q[NS].x_neg ? PI_S : '0;
    end else if (!fl_q[NS].y_neg) begin
      if (q_ext[Q_WIDTH]) begin
        ang_sel = '0;
      end else if (q_ext > PI_S) begin
        ang_sel = PI_S;
      end else begin
        ang_sel = q_ext;
      end
    end else begin
      if (q_low < PI_S) begin
        ang_sel = PI_S;
      end else if (q_low > TWO_PI_M1) begin
        ang_sel = TWO_PI_M1;
      end else begin
        ang_sel = q_low;
      end
    end
  end

  assign ang_res = ang_sel[ANGLE_WIDTH-1:0];

  // output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pol_o.ready) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || pol_o.ready) begin
      out_v_q <= sv_q[NS];
    end else if (sv_q[NS]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pol_o.ready) begin
        rad_q <= skid_rad_q;
        ang_q <= skid_ang_q;
      end
    end else if (!out_v_q || pol_o.ready) begin
      rad_q <= rad_res;
      ang_q <= ang_res;
    end else begin
      skid_rad_q <= rad_res;
      skid_ang_q <= ang_res;
    end
  end

  assign pol_o.valid  = out_v_q;
  assign pol_o.radius = rad_q;
  assign pol_o.angle  = ang_q;

endmodule

`default_nettype wire

// ===== design/c2p_checker.sv =====
// c2p_checker: port-level assertions for cartesian_to_polar_unit, bound to it
// depends on c2p_pkg and cartesian_to_polar_unit
`default_nettype none

module c2p_checker
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [COORD_WIDTH-1:0] radius_i,
  input wire logic [ANGLE_WIDTH-1:0] angle_i
);

  localparam logic [ANGLE_WIDTH-1:0] TWO_PI_A = ANGLE_WIDTH'(TWO_PI_Q13);

  // a stalled result stays offered with the same payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(radius_i) && $stable(angle_i))
    else $error("result dropped or changed while stalled");

  // input back-pressure only when a result is already waiting
  a_ready_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  // after a backpressured result is taken, input is free again
  a_ready_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i && out_ready_i |=> in_ready_i)
    else $error("input still stalled after result transaction");

  // only the origin has radius zero, and it maps to angle zero
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (radius_i == '0) |-> (angle_i == '0))
    else $error("zero radius with nonzero angle");

  // angle stays below two pi
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (angle_i < TWO_PI_A))
    else $error("angle out of range");

endmodule

bind cartesian_to_polar_unit c2p_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_c2p_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pt_i.ready),
  .out_valid_i (pol_o.valid),
  .out_ready_i (pol_o.ready),
  .radius_i    (pol_o.radius),
  .angle_i     (pol_o.angle)
);

`default_nettype wire
